### rtl/priority_task_queue_unit_defines.svh
// assertion macros shared by the priority task queue checker
// expects signals named clock and reset in the scope of use
`ifndef PRIORITY_TASK_QUEUE_UNIT_DEFINES_SVH
`define PRIORITY_TASK_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PTQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptq assertion failed");

// next-cycle implication, off while reset is high
`define PTQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptq assertion failed");

// next-cycle implication that also runs through reset
`define PTQ_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ptq assertion failed");

`endif

### rtl/ptq_pkg.sv
// types, codes and sizes for the priority task queue
// no dependencies
`default_nettype none

package ptq_pkg;

   // queue sizing
   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int PRIO_W        = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;
   localparam int CNT_W         = $clog2(CAPACITY + 1);

   // fixed field widths of the stream words
   localparam int FIELD_PRIO_W = 8;
   localparam int DATA_W       = 32;
   localparam int OCC_W        = 5;
   localparam int STATUS_W     = 2;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 80;
   localparam int RSP_TUSER_W  = 3;

   // action codes
   localparam logic ACTION_ENQ = 1'b0;
   localparam logic ACTION_POP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // one stored task
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] handler;
      logic [DATA_W-1:0] argument;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type ent;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/ptq_cell.sv
// one slot of the sorted task chain
// depends on ptq_pkg
`default_nettype none

module ptq_cell import ptq_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire logic      prev_place,
   input  wire entry_type prev_ent,
   input  wire logic      prev_valid,
   input  wire entry_type next_ent,
   input  wire logic      next_valid,
   output      entry_type ent,
   output      logic      valid,
   output      logic      place
);

   entry_type ent_ff, ent_in;
   logic      valid_ff, valid_in;

   // new task goes here or earlier: slot empty or holds a strictly lower priority
   assign place = !valid_ff || (cmd.ent.prio > ent_ff.prio);

   // insert: take the new task at the boundary, shift up behind it
   // pop: shift down toward the head
   always_comb begin
      ent_in   = ent_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (place && !prev_place) begin
            ent_in   = cmd.ent;
            valid_in = 1'b1;
         end else if (place) begin
            ent_in   = prev_ent;
            valid_in = prev_valid;
         end
      end else if (cmd.pop) begin
         ent_in   = next_ent;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ent   = ent_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

### rtl/priority_task_queue_unit.sv
// Priority task queue: the rsp word of an accepted req word is registered and presented in the next cycle.
// Throughput one word per cycle, enqueue or pop, held by the rsp register only
// when rsp_tready is low; each cell compares combinationally and shifts as the word is accepted.
// Reset clears every slot valid bit, the task count and the rsp valid flag at once;
// no clearing pass, the queue takes words in the first cycle after reset.
// depends on ptq_pkg and ptq_cell
`default_nettype none

module priority_task_queue_unit import ptq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // priority_req[7:0], handler[39:8], argument[71:40]
   input  wire logic                   req_tuser,  // action
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_priority[7:0], out_handler[39:8],
                                                   // out_argument[71:40], occupancy[76:72], zero
   output      logic [RSP_TUSER_W-1:0] rsp_tuser   // status[1:0], task_valid[2]
);

   cmd_type   cmd;
   entry_type cell_ent   [CAPACITY];
   logic      cell_valid [CAPACITY];
   logic      cell_place [CAPACITY];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, req_fire;

   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]  rsp_user_ff, rsp_user_in;
   logic [STATUS_W-1:0]     status;
   entry_type               out_ent;

   // input handshake: the rsp register frees as its word leaves
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   // command to the chain
   always_comb begin
      cmd.insert       = req_fire && (req_tuser == ACTION_ENQ) && !full;
      cmd.pop          = req_fire && (req_tuser == ACTION_POP) && !empty;
      cmd.ent.prio     = PRIO_W'(req_tdata[FIELD_PRIO_W-1:0]);
      cmd.ent.handler  = req_tdata[FIELD_PRIO_W +: DATA_W];
      cmd.ent.argument = req_tdata[FIELD_PRIO_W + DATA_W +: DATA_W];
   end

   // chain of cells, head at slot 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      prev_place, prev_valid, next_valid;
      entry_type prev_ent, next_ent;

      if (i == 0) begin : g_head
         assign prev_place = 1'b0;
         assign prev_valid = 1'b0;
         assign prev_ent   = '0;
      end else begin : g_body
         assign prev_place = cell_place[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_ent   = cell_ent[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_ent   = '0;
      end else begin : g_link
         assign next_valid = cell_valid[i+1];
         assign next_ent   = cell_ent[i+1];
      end

      ptq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_place (prev_place),
         .prev_ent   (prev_ent),
         .prev_valid (prev_valid),
         .next_ent   (next_ent),
         .next_valid (next_valid),
         .ent        (cell_ent[i]),
         .valid      (cell_valid[i]),
         .place      (cell_place[i])
      );
   end

   // task count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result word
   always_comb begin
      status = STATUS_OK;
      if (req_tuser == ACTION_ENQ && full) begin
         status = STATUS_FULL;
      end else if (req_tuser == ACTION_POP && empty) begin
         status = STATUS_EMPTY;
      end
      out_ent     = cmd.pop ? cell_ent[0] : '0;
      rsp_data_in = {3'b000, OCC_W'(count_in), out_ent.argument, out_ent.handler,
                     FIELD_PRIO_W'(out_ent.prio)};
      rsp_user_in = {cmd.pop, status};
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### rtl/ptq_checker.sv
// port-level checks for priority_task_queue_unit, bound to the top level
// depends on ptq_pkg and priority_task_queue_unit_defines.svh
`default_nettype none

`include "priority_task_queue_unit_defines.svh"

module ptq_port_checks import ptq_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic [STATUS_W-1:0] status;
   logic [OCC_W-1:0]    occupancy;
   logic                task_valid;

   assign status     = rsp_tuser[STATUS_W-1:0];
   assign task_valid = rsp_tuser[STATUS_W];
   assign occupancy  = rsp_tdata[FIELD_PRIO_W + 2*DATA_W +: OCC_W];

   // a stalled word holds
   `PTQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a returned task always comes with ok status
   `PTQ_ASSERT_NOW(a_task_ok, rsp_tvalid && task_valid, status == STATUS_OK)

   // empty pop reports no task and zero occupancy
   `PTQ_ASSERT_NOW(a_empty_pop, rsp_tvalid && status == STATUS_EMPTY,
                   !task_valid && occupancy == '0)

   // a dropped enqueue only happens with every slot in use
   `PTQ_ASSERT_NOW(a_full_drop, rsp_tvalid && status == STATUS_FULL,
                   occupancy == OCC_W'(CAPACITY) && !task_valid)

   // nothing is presented right after reset
   `PTQ_ASSERT_RST(a_reset_idle, reset, !rsp_tvalid)

endmodule

bind priority_task_queue_unit ptq_port_checks u_ptq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/ptq_checker.sv
// checker for the priority task queue: watches the req and rsp streams,
// predicts every rsp word and compares it field by field; depends on ptq_pkg
`default_nettype none

module ptq_checker import ptq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // priority_req[7:0], handler[39:8], argument[71:40]
   input  wire logic                   req_tuser,  // action
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_priority[7:0], out_handler[39:8],
                                                   // out_argument[71:40], occupancy[76:72], zero
   input  wire logic [RSP_TUSER_W-1:0] rsp_tuser,  // status[1:0], task_valid[2]
   output int                          fail_count,
   output int                          pending_count
);

   // one predicted rsp word
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    task_valid;
      logic [FIELD_PRIO_W-1:0] prio;
      logic [DATA_W-1:0]       handler;
      logic [DATA_W-1:0]       argument;
      logic [OCC_W-1:0]        occupancy;
   } outcome_type;

   // tasks held by the queue, oldest first
   entry_type   stored_tasks[$];
   // rsp words still to come, oldest first
   outcome_type pending_outcomes[$];
   int          failures = 0;

   // apply one req word to the task list and work out its rsp word
   function automatic outcome_type schedule_task(input logic action,
                                                 input logic [FIELD_PRIO_W-1:0] prio,
                                                 input logic [DATA_W-1:0] handler,
                                                 input logic [DATA_W-1:0] argument);
      outcome_type outcome;
      entry_type   ent;
      int          best;
      outcome = '0;
      if (action == ACTION_ENQ) begin
         if (stored_tasks.size() >= CAPACITY) begin
            outcome.status = STATUS_FULL;
         end else begin
            ent.prio     = prio[PRIO_W-1:0];
            ent.handler  = handler;
            ent.argument = argument;
            stored_tasks.push_back(ent);
         end
      end else if (stored_tasks.size() == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         // strict compare keeps the oldest among equal priorities
         best = 0;
         for (int i = 1; i < stored_tasks.size(); i++) begin
            if (stored_tasks[i].prio > stored_tasks[best].prio) best = i;
         end
         outcome.task_valid = 1'b1;
         outcome.prio       = FIELD_PRIO_W'(stored_tasks[best].prio);
         outcome.handler    = stored_tasks[best].handler;
         outcome.argument   = stored_tasks[best].argument;
         stored_tasks.delete(best);
      end
      outcome.occupancy = OCC_W'(stored_tasks.size());
      return outcome;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         failures++;
      end
   endtask

   // compare the rsp word of this edge first, then record the req word
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         stored_tasks.delete();
         pending_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $error("rsp word with no pending req: tdata 0x%0h tuser 0x%0h",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser[1:0]));
               check_field("task_valid", 32'(want.task_valid), 32'(rsp_tuser[2]));
               check_field("out_priority", 32'(want.prio), 32'(rsp_tdata[7:0]));
               check_field("out_handler", want.handler, rsp_tdata[39:8]);
               check_field("out_argument", want.argument, rsp_tdata[71:40]);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_tdata[76:72]));
               check_field("padding", 32'h0, 32'(rsp_tdata[79:77]));
            end
         end
         if (req_tvalid && req_tready) begin
            pending_outcomes.push_back(schedule_task(req_tuser, req_tdata[7:0],
                                                     req_tdata[39:8], req_tdata[71:40]));
         end
      end
      fail_count    <= failures;
      pending_count <= pending_outcomes.size();
   end

endmodule

`default_nettype wire

### tb/priority_task_queue_unit_tb.sv
// top of the priority task queue testbench: clock, reset, req stimulus,
// rsp back-pressure, watchdog and verdict; depends on ptq_pkg, ptq_checker and the block
`default_nettype none

module priority_task_queue_unit_tb;
   import ptq_pkg::*;

   localparam int RANDOM_WORDS   = 550;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = ACTION_ENQ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   int fail_count;
   int pending_count;
   int send_idle_pct = 36;
   int recv_idle_pct = 64;
   int quiet_cycles  = 0;

   priority_task_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ptq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // rsp back-pressure
   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // offer one req word after random gaps and hold it until accepted
   task automatic send_word(input logic action, input logic [7:0] prio,
                            input logic [31:0] handler, input logic [31:0] argument);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {argument, handler, prio};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending until every rsp word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_priority();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 8'($urandom_range(3));     // dense ties
      else if (roll < 80) return 8'($urandom_range(255));
      else return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
   endfunction

   initial begin
      int   enq_bias;
      logic action;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pop on empty, priority and data extremes, ties, full queue
      send_word(ACTION_POP, 8'hA5, $urandom, $urandom);
      send_word(ACTION_ENQ, 8'h00, 32'h0000_0000, 32'h0000_0000);
      send_word(ACTION_ENQ, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 14; i++) begin
         send_word(ACTION_ENQ, (i < 6) ? 8'h05 : 8'(i * 37), 32'h1000 + i, $urandom);
      end
      send_word(ACTION_ENQ, 8'h7E, 32'hDEAD_0000, 32'h0000_BEEF);   // dropped, queue full
      for (int i = 0; i < 7; i++) begin
         send_word(ACTION_POP, 8'($urandom), $urandom, $urandom);
      end

      // random: enqueue-heavy, balanced and pop-heavy stretches
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 64;
            recv_idle_pct = 36;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         enq_bias = 50;
         for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
            if (n % 32 == 0) begin
               case ($urandom_range(2))
                  0: enq_bias = 85;
                  1: enq_bias = 50;
                  default: enq_bias = 15;
               endcase
            end
            action = ($urandom_range(99) < enq_bias) ? ACTION_ENQ : ACTION_POP;
            send_word(action, pick_priority(), $urandom, $urandom);
         end
         wait_drained();
      end

      // settle, then verdict
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/ptq_pkg.sv
rtl/ptq_cell.sv
rtl/priority_task_queue_unit.sv
rtl/ptq_checker.sv
tb/ptq_checker.sv
tb/priority_task_queue_unit_tb.sv
